### design/apcp_pkg.sv
// Shared types and character constants for the ASCII pixel command parser.
package apcp_pkg;

	localparam int FRAME_WIDTH = 25;

	localparam logic [7:0] CHAR_SET   = 8'h53;
	localparam logic [7:0] CHAR_CLEAR = 8'h43;
	localparam logic [7:0] CHAR_GET   = 8'h47;
	localparam logic [7:0] CHAR_RESET = 8'h52;
	localparam logic [7:0] DIGIT_ZERO = 8'h30;

	typedef enum logic [1:0] {
		STATUS_OK     = 2'd0,
		STATUS_RANGE  = 2'd1,
		STATUS_OPCODE = 2'd2
	} status_t;

	typedef enum logic [2:0] {
		OP_NONE,
		OP_SET,
		OP_CLEAR,
		OP_GET,
		OP_RESET
	} op_t;

	typedef enum logic [1:0] {
		POS_OPCODE,
		POS_COLUMN,
		POS_ROW
	} pos_t;

	typedef struct packed {
		status_t status;
		op_t     op;
	} cmd_t;

endpackage

### design/ascii_pixel_command_parser.sv
// Top level of the ASCII pixel command parser with its frame store.
//
// The rx channel (rx_valid, rx_stall, rx_byte) takes one character per
// transfer. Every three characters form a command: an opcode ('S' set,
// 'C' clear, 'G' get, 'R' reset frame), a column digit and a row digit.
// After the row digit one result transfer leaves on the res channel
// (res_valid, res_stall, status, pixel_value, frame_bits); the first two
// characters of a command give no result.
// A character is captured in an input register at its transfer. From there
// the decode and the frame update (one cell, or the whole frame on reset)
// run and load the result register, which drives res_valid.
// The block takes one character in every cycle. The only thing that can
// hold it up is a full result register under res_stall: then a row digit
// waiting in the input register cannot execute and rx_stall is raised.
// Opcode and column characters still move through, since they only land
// in the command holding registers.
// Reset clears the byte position, the held opcode and column, the frame
// store (all pixels off) and both valid flags.
// frame_bits reports bit row*GRID_SIZE+column; pixels at index 25 and
// above are kept but not reported.
module ascii_pixel_command_parser #(
	parameter int GRID_SIZE = 5
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        rx_valid,
	output logic        rx_stall,
	input  logic [7:0]  rx_byte,
	output logic        res_valid,
	input  logic        res_stall,
	output logic [1:0]  status,
	output logic        pixel_value,
	output logic [24:0] frame_bits
);

	localparam int IDX_W  = $clog2(GRID_SIZE);
	localparam int CELLS  = GRID_SIZE * GRID_SIZE;
	localparam int CELL_W = $clog2(CELLS);
	localparam int FW     = apcp_pkg::FRAME_WIDTH;

	// Input register stage.
	logic       valid_s1;
	logic [7:0] byte_s1;

	// Command assembly state.
	apcp_pkg::pos_t pos_q;
	apcp_pkg::pos_t pos_d;
	logic [7:0]     opcode_q;
	logic [7:0]     column_q;

	// Frame store, one bit per cell, indexed row*GRID_SIZE+column.
	logic [CELLS-1:0] frame_q;
	logic [CELLS-1:0] frame_d;
	logic [CELLS-1:0] cell_mask;
	logic [FW-1:0]    frame_pack;

	// Result register.
	logic              res_valid_q;
	apcp_pkg::status_t res_status_q;
	logic              res_pixel_q;
	logic [FW-1:0]     res_frame_q;

	apcp_pkg::cmd_t     cmd;
	logic [IDX_W-1:0]   col_idx;
	logic [IDX_W-1:0]   row_idx;
	logic [CELL_W-1:0]  cell_idx;
	logic               pixel_d;
	logic               adv_s1;
	logic               exec;

	// A character in the input register moves on unless it is a row digit
	// and the result register is full and stalled.
	assign adv_s1   = valid_s1 &&
		((pos_q != apcp_pkg::POS_ROW) || !res_valid_q || !res_stall);
	assign exec     = adv_s1 && (pos_q == apcp_pkg::POS_ROW);
	assign rx_stall = valid_s1 && !adv_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!rx_stall) begin
			valid_s1 <= rx_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (rx_valid && !rx_stall) begin
			byte_s1 <= rx_byte;
		end
	end

	// Byte position within the command.
	always_comb begin
		pos_d = pos_q;
		if (adv_s1) begin
			case (pos_q)
				apcp_pkg::POS_OPCODE: pos_d = apcp_pkg::POS_COLUMN;
				apcp_pkg::POS_COLUMN: pos_d = apcp_pkg::POS_ROW;
				apcp_pkg::POS_ROW:    pos_d = apcp_pkg::POS_OPCODE;
				default:              pos_d = apcp_pkg::POS_OPCODE;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q    <= apcp_pkg::POS_OPCODE;
			opcode_q <= '0;
			column_q <= '0;
		end else begin
			pos_q <= pos_d;
			if (adv_s1 && (pos_q == apcp_pkg::POS_OPCODE)) begin
				opcode_q <= byte_s1;
			end
			if (adv_s1 && (pos_q == apcp_pkg::POS_COLUMN)) begin
				column_q <= byte_s1;
			end
		end
	end

	// The row digit is the character in the input register itself.
	apcp_cmd_decode #(
		.GRID_SIZE(GRID_SIZE)
	) u_decode (
		.opcode_byte(opcode_q),
		.column_byte(column_q),
		.row_byte   (byte_s1),
		.cmd        (cmd),
		.col_idx    (col_idx),
		.row_idx    (row_idx)
	);

	assign cell_idx  = CELL_W'(row_idx) * CELL_W'(GRID_SIZE) + CELL_W'(col_idx);
	assign cell_mask = {{(CELLS-1){1'b0}}, 1'b1} << cell_idx;

	// Frame update and pixel read. The decoder reports OP_NONE whenever the
	// status is not ok, so a failing command leaves the frame alone.
	always_comb begin
		frame_d = frame_q;
		pixel_d = 1'b0;
		if (exec) begin
			case (cmd.op)
				apcp_pkg::OP_SET:   frame_d = frame_q | cell_mask;
				apcp_pkg::OP_CLEAR: frame_d = frame_q & ~cell_mask;
				apcp_pkg::OP_RESET: frame_d = '0;
				apcp_pkg::OP_GET:   pixel_d = frame_q[cell_idx];
				default:            frame_d = frame_q;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_q <= '0;
		end else if (exec) begin
			frame_q <= frame_d;
		end
	end

	// The reported frame holds the first 25 cells, zero-filled for small grids.
	generate
		if (CELLS >= FW) begin : g_pack_trim
			assign frame_pack = frame_d[FW-1:0];
		end else begin : g_pack_fill
			assign frame_pack = {{(FW-CELLS){1'b0}}, frame_d};
		end
	endgenerate

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (exec) begin
			res_valid_q <= 1'b1;
		end else if (!res_stall) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (exec) begin
			res_status_q <= cmd.status;
			res_pixel_q  <= pixel_d;
			res_frame_q  <= frame_pack;
		end
	end

	assign res_valid   = res_valid_q;
	assign status      = res_status_q;
	assign pixel_value = res_pixel_q;
	assign frame_bits  = res_frame_q;

	// A completed command always produces a pending result.
	a_exec_gives_result: assert property (@(posedge clk) disable iff (!arst_n)
		exec |=> res_valid_q)
		else $error("row digit executed without loading a result");

	// Only a row digit waiting on a stalled result may hold up the rx channel.
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		rx_stall |-> (valid_s1 && (pos_q == apcp_pkg::POS_ROW) && res_valid_q && res_stall))
		else $error("rx stalled without a blocked row digit");

	// A failing command leaves the frame untouched.
	a_error_keeps_frame: assert property (@(posedge clk) disable iff (!arst_n)
		(exec && (cmd.status != apcp_pkg::STATUS_OK)) |=> $stable(frame_q))
		else $error("frame changed by a failing command");

	// A set pixel can only be reported by a get command.
	a_pixel_only_get: assert property (@(posedge clk) disable iff (!arst_n)
		(exec && pixel_d) |-> (cmd.op == apcp_pkg::OP_GET))
		else $error("pixel reported for a command other than get");

	// The reset command empties the whole frame.
	a_reset_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(exec && (cmd.op == apcp_pkg::OP_RESET)) |=> (frame_q == '0))
		else $error("frame not empty after reset command");

endmodule

### design/apcp_cmd_decode.sv
// Command decoder: digit range checks, opcode decode and grid indexes.
module apcp_cmd_decode #(
	parameter int GRID_SIZE = 5
) (
	input  logic [7:0]                   opcode_byte,
	input  logic [7:0]                   column_byte,
	input  logic [7:0]                   row_byte,
	output apcp_pkg::cmd_t               cmd,
	output logic [$clog2(GRID_SIZE)-1:0] col_idx,
	output logic [$clog2(GRID_SIZE)-1:0] row_idx
);

	localparam int IDX_W = $clog2(GRID_SIZE);

	logic [7:0] col_off;
	logic [7:0] row_off;
	logic       col_ok;
	logic       row_ok;

	assign col_off = column_byte - apcp_pkg::DIGIT_ZERO;
	assign row_off = row_byte - apcp_pkg::DIGIT_ZERO;
	assign col_ok  = (column_byte >= apcp_pkg::DIGIT_ZERO) && (col_off < 8'(GRID_SIZE));
	assign row_ok  = (row_byte >= apcp_pkg::DIGIT_ZERO) && (row_off < 8'(GRID_SIZE));
	assign col_idx = col_off[IDX_W-1:0];
	assign row_idx = row_off[IDX_W-1:0];

	// The digits are checked first, so a bad digit wins over a bad opcode.
	always_comb begin
		cmd.status = apcp_pkg::STATUS_OK;
		cmd.op     = apcp_pkg::OP_NONE;
		if (!col_ok || !row_ok) begin
			cmd.status = apcp_pkg::STATUS_RANGE;
		end else begin
			case (opcode_byte)
				apcp_pkg::CHAR_SET:   cmd.op = apcp_pkg::OP_SET;
				apcp_pkg::CHAR_CLEAR: cmd.op = apcp_pkg::OP_CLEAR;
				apcp_pkg::CHAR_GET:   cmd.op = apcp_pkg::OP_GET;
				apcp_pkg::CHAR_RESET: cmd.op = apcp_pkg::OP_RESET;
				default:              cmd.status = apcp_pkg::STATUS_OPCODE;
			endcase
		end
	end

endmodule
